/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the packet checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: %m");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/gpcc_pkg.sv */
// ---------------------------------------------------------------------------
// gpcc_pkg
// Types, byte positions and the CRC-16 byte step for the packet checker.
// ---------------------------------------------------------------------------
`default_nettype none

package gpcc_pkg;

	localparam int POS_W = 4;

	typedef logic [POS_W-1:0] gpcc_pos_t;

	// byte positions within a packet
	localparam gpcc_pos_t POS_BTN_LO = 4'd0;
	localparam gpcc_pos_t POS_BTN_HI = 4'd1;
	localparam gpcc_pos_t POS_STAT   = 4'd4;
	localparam gpcc_pos_t POS_LX     = 4'd5;
	localparam gpcc_pos_t POS_LY     = 4'd6;
	localparam gpcc_pos_t POS_RX     = 4'd7;
	localparam gpcc_pos_t POS_RY     = 4'd8;
	localparam gpcc_pos_t POS_CRC_HI = 4'd9;
	localparam gpcc_pos_t POS_LAST   = 4'd10;
	localparam gpcc_pos_t CRC_COVER  = 4'd9;

	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_SEED  = 16'hFFFF;
	localparam logic [7:0] STICK_KEEP = 8'hFE;
	localparam int MUTED_BIT = 7;
	localparam int POWER_BIT = 4;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_SHORT   = 2'd2
	} gpcc_status_t;

	typedef struct packed {
		gpcc_status_t status;
		logic [15:0]  buttons;
		logic [7:0]   left_x;
		logic [7:0]   left_y;
		logic [7:0]   right_x;
		logic [7:0]   right_y;
		logic         l2_pressed;
		logic         r2_pressed;
		logic         muted;
		logic         power_key;
		logic [15:0]  computed_crc;
	} gpcc_result_t;

	// One byte of CRC-16-CCITT, MSB first, eight bit steps
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* sv/gpcc_parser.sv */
// ---------------------------------------------------------------------------
// gpcc_parser
// Tracks the byte position, runs the CRC and builds the packet result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpcc_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  acc,
	input  wire logic [7:0]            rx_byte,
	input  wire logic                  packet_start,
	output logic                       res_valid,
	output gpcc_pkg::gpcc_result_t     res
);
	import gpcc_pkg::*;

	gpcc_pos_t   pos_q;
	logic [15:0] crc_q;
	logic [7:0]  btn_lo_q;
	logic [7:0]  btn_hi_q;
	logic [7:0]  stat_q;
	logic [7:0]  lx_q;
	logic [7:0]  ly_q;
	logic [7:0]  rx_q;
	logic [7:0]  ry_q;
	logic [7:0]  crc_hi_q;
	logic [15:0] crc_rx;
	logic        last_byte;

	assign crc_rx    = {crc_hi_q, rx_byte};
	assign last_byte = acc && !packet_start && (pos_q == POS_LAST);

	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (acc && packet_start && (pos_q != POS_BTN_LO)) begin
			res_valid  = 1'b1;
			res.status = STATUS_SHORT;
		end else if (last_byte) begin
			res_valid        = 1'b1;
			res.computed_crc = crc_q;
			if (crc_q != crc_rx) begin
				res.status = STATUS_CRC_ERR;
			end else begin
				res.status     = STATUS_OK;
				res.buttons    = {btn_hi_q, btn_lo_q};
				res.left_x     = lx_q;
				res.left_y     = ly_q;
				res.right_x    = rx_q & STICK_KEEP;
				res.right_y    = ry_q & STICK_KEEP;
				res.l2_pressed = ry_q[0];
				res.r2_pressed = rx_q[0];
				res.muted      = stat_q[MUTED_BIT];
				res.power_key  = stat_q[POWER_BIT];
			end
		end
	end

	// position and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_SEED;
		end else if (acc) begin
			if (packet_start) begin
				pos_q <= POS_BTN_HI;
				crc_q <= crc16_byte(CRC_SEED, rx_byte);
			end else if (pos_q == POS_LAST) begin
				pos_q <= '0;
				crc_q <= CRC_SEED;
			end else if (pos_q != POS_BTN_LO) begin
				pos_q <= pos_q + gpcc_pos_t'(1);
				if (pos_q < CRC_COVER) begin
					crc_q <= crc16_byte(crc_q, rx_byte);
				end
			end
		end
	end

	// packet bytes needed for the result; voltage bytes are dropped
	always_ff @(posedge clk) begin
		if (acc && packet_start) begin
			btn_lo_q <= rx_byte;
		end else if (acc && (pos_q != POS_BTN_LO)) begin
			case (pos_q)
				POS_BTN_HI: btn_hi_q <= rx_byte;
				POS_STAT:   stat_q   <= rx_byte;
				POS_LX:     lx_q     <= rx_byte;
				POS_LY:     ly_q     <= rx_byte;
				POS_RX:     rx_q     <= rx_byte;
				POS_RY:     ry_q     <= rx_byte;
				POS_CRC_HI: crc_hi_q <= rx_byte;
				default: begin
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_pos_range, clk, arst_n, pos_q <= POS_LAST)
	`ASSERT_NEXT(a_last_to_idle, clk, arst_n, last_byte, pos_q == POS_BTN_LO)
	`ASSERT_IMPLIES(a_ok_crc_match, clk, arst_n, res_valid && (res.status == STATUS_OK), crc_q == crc_rx)

endmodule

`default_nettype wire

/* sv/gamepad_packet_crc_checker.sv */
// ---------------------------------------------------------------------------
// gamepad_packet_crc_checker
// Checks the CRC-16 of 11-byte controller packets and unpacks their fields.
// ---------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------
//  input    | in_valid / in_stall | rx_byte, packet_start
//  output   | out_valid/out_stall | status, buttons, sticks, L2/R2, flags, CRC
//
// One byte is taken per cycle while in_stall is low; the CRC comparison and the
// field unpacking sit between the packet registers and the result register.
// The result of the byte that ends or cuts short a packet is registered.
// A full result register and a one-entry skid register absorb output stalls;
// the input stalls only while the skid register holds a waiting transfer.
// Reset (arst_n low) returns to idle: no packet open, CRC at its seed.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gamepad_packet_crc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        packet_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      buttons,
	output logic [7:0]       left_x,
	output logic [7:0]       left_y,
	output logic [7:0]       right_x,
	output logic [7:0]       right_y,
	output logic             l2_pressed,
	output logic             r2_pressed,
	output logic             muted,
	output logic             power_key,
	output logic [15:0]      computed_crc
);
	import gpcc_pkg::*;

	logic         in_acc;
	logic         out_take;
	logic         res_valid;
	gpcc_result_t res;
	gpcc_result_t out_q;
	gpcc_result_t skid_q;
	logic         out_valid_q;
	logic         skid_valid_q;

	// stall the input only when the skid slot is taken
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	gpcc_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc          (in_acc),
		.rx_byte      (rx_byte),
		.packet_start (packet_start),
		.res_valid    (res_valid),
		.res          (res)
	);

	// output valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// advance the skid entry once the output transfer completes
			if (out_take) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// result payloads
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_take) begin
			if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign buttons      = out_q.buttons;
	assign left_x       = out_q.left_x;
	assign left_y       = out_q.left_y;
	assign right_x      = out_q.right_x;
	assign right_y      = out_q.right_y;
	assign l2_pressed   = out_q.l2_pressed;
	assign r2_pressed   = out_q.r2_pressed;
	assign muted        = out_q.muted;
	assign power_key    = out_q.power_key;
	assign computed_crc = out_q.computed_crc;

	`ASSERT_IMPLIES(a_skid_needs_out, clk, arst_n, skid_valid_q, out_valid_q)
	`ASSERT_IMPLIES(a_skid_fill_on_stall, clk, arst_n, $rose(skid_valid_q), $past(out_valid_q && out_stall))
	`ASSERT_IMPLIES(a_out_drop_on_take, clk, arst_n, $fell(out_valid_q), $past(!out_stall))

endmodule

`default_nettype wire
